// ===== rtl/core/pipc_pkg.sv =====
// shared types and constants of the point-in-polygon crossing core
package pipc_pkg;

   localparam int FIELD_WIDTH    = 32;
   localparam int REQ_DATA_WIDTH = 4 * FIELD_WIDTH;
   localparam int RSP_DATA_WIDTH = 8;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QPTR_WIDTH     = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic first;
      logic last;
      logic up;
      logic down;
   } edge_flags_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== rtl/core/pipc_front.sv =====
// front end: latches the query point, forms edge deltas and classifies the crossing
module pipc_front #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept,
   input  logic [pipc_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,
   input  logic                                  req_tuser,
   input  logic                                  req_tlast,
   output logic [4*(COORD_WIDTH+1)-1:0]          edge_data,
   output pipc_pkg::edge_flags_type              edge_flags
);
   import pipc_pkg::*;

   localparam int DW    = COORD_WIDTH + 1;
   localparam int EXT_W = (COORD_WIDTH > FIELD_WIDTH) ? COORD_WIDTH : FIELD_WIDTH;

   logic [EXT_W-1:0] vx_ext, vy_ext, px_ext, py_ext;
   logic signed [COORD_WIDTH-1:0] vx, vy, px, py, qx, qy;
   logic signed [COORD_WIDTH-1:0] prev_x_ff, prev_y_ff, query_x_ff, query_y_ff;
   logic signed [COORD_WIDTH-1:0] prev_x_in, prev_y_in, query_x_in, query_y_in;
   logic signed [DW-1:0] dx0, dy0, dx1, dy1;

   // fields wider than the coordinate keep only their low bits
   assign vx_ext = EXT_W'(req_tdata[FIELD_WIDTH-1:0]);
   assign vy_ext = EXT_W'(req_tdata[2*FIELD_WIDTH-1:FIELD_WIDTH]);
   assign px_ext = EXT_W'(req_tdata[3*FIELD_WIDTH-1:2*FIELD_WIDTH]);
   assign py_ext = EXT_W'(req_tdata[4*FIELD_WIDTH-1:3*FIELD_WIDTH]);
   assign vx = vx_ext[COORD_WIDTH-1:0];
   assign vy = vy_ext[COORD_WIDTH-1:0];
   assign px = px_ext[COORD_WIDTH-1:0];
   assign py = py_ext[COORD_WIDTH-1:0];

   assign qx = req_tuser ? px : query_x_ff;
   assign qy = req_tuser ? py : query_y_ff;

   assign dx0 = DW'(prev_x_ff) - DW'(qx);
   assign dy0 = DW'(prev_y_ff) - DW'(qy);
   assign dx1 = DW'(vx) - DW'(qx);
   assign dy1 = DW'(vy) - DW'(qy);

   assign edge_data        = {dy1, dx1, dy0, dx0};
   assign edge_flags.first = req_tuser;
   assign edge_flags.last  = req_tlast;
   assign edge_flags.up    = (dy0 <= 0) && (dy1 > 0);
   assign edge_flags.down  = (dy0 > 0) && (dy1 <= 0);

   always_comb begin
      prev_x_in  = prev_x_ff;
      prev_y_in  = prev_y_ff;
      query_x_in = query_x_ff;
      query_y_in = query_y_ff;
      if (accept) begin
         prev_x_in  = vx;
         prev_y_in  = vy;
         query_x_in = qx;
         query_y_in = qy;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff  <= '0;
         prev_y_ff  <= '0;
         query_x_ff <= '0;
         query_y_ff <= '0;
      end else begin
         prev_x_ff  <= prev_x_in;
         prev_y_ff  <= prev_y_in;
         query_x_ff <= query_x_in;
         query_y_ff <= query_y_in;
      end
   end

endmodule

// ===== rtl/core/pipc_queue.sv =====
// short queue of classified edges between front and back
module pipc_queue #(
   parameter int DATA_WIDTH = 132
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic [DATA_WIDTH-1:0]         push_data,
   input  pipc_pkg::edge_flags_type      push_flags,
   input  logic                          pop,
   output logic [DATA_WIDTH-1:0]         head_data,
   output pipc_pkg::edge_flags_type      head_flags,
   output pipc_pkg::queue_status_type    status
);
   import pipc_pkg::*;

   logic [DATA_WIDTH-1:0] data_ff [QUEUE_DEPTH];
   edge_flags_type        flags_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QPTR_WIDTH:0]   count_ff, count_in;

   assign status.full  = (count_ff == (QPTR_WIDTH+1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_data    = data_ff[rd_ptr_ff];
   assign head_flags   = flags_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff]  <= push_data;
         flags_ff[wr_ptr_ff] <= push_flags;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/core/pipc_back.sv =====
// back end: cross-product pipeline, crossing parity and result register
module pipc_back #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              queue_empty,
   input  logic [4*(COORD_WIDTH+1)-1:0]      edge_data,
   input  pipc_pkg::edge_flags_type          edge_flags,
   output logic                              pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic                              inside_res
);
   import pipc_pkg::*;

   localparam int DW  = COORD_WIDTH + 1;
   localparam int LW  = DW / 2;
   localparam int HW  = DW - LW;
   localparam int PLW = DW + LW + 1;
   localparam int PHW = DW + HW;
   localparam int PW  = 2 * DW;

   logic signed [DW-1:0]  dx0, dy0, dx1, dy1;
   logic signed [LW:0]    dy0_lo, dy1_lo;
   logic signed [HW-1:0]  dy0_hi, dy1_hi;
   logic                  advance;

   // stage a: split partial products
   logic signed [PLW-1:0] a_lo0_ff, a_lo1_ff, a_lo0_in, a_lo1_in;
   logic signed [PHW-1:0] a_hi0_ff, a_hi1_ff, a_hi0_in, a_hi1_in;
   edge_flags_type        a_flags_ff;
   logic                  a_valid_ff, a_valid_in;

   // stage b: full products
   logic signed [PW-1:0]  b_prod0_ff, b_prod1_ff, b_prod0_in, b_prod1_in;
   edge_flags_type        b_flags_ff;
   logic                  b_valid_ff, b_valid_in;

   logic signed [PW:0]    num;
   logic                  num_neg, num_pos, toggle, parity_new;
   logic                  parity_ff, parity_in, rsp_valid_ff, rsp_valid_in;
   logic                  inside_ff, inside_in;

   assign advance = !rsp_valid_ff || rsp_tready;
   assign pop     = advance && !queue_empty;

   assign {dy1, dx1, dy0, dx0} = edge_data;
   assign dy0_lo = $signed({1'b0, dy0[LW-1:0]});
   assign dy1_lo = $signed({1'b0, dy1[LW-1:0]});
   assign dy0_hi = dy0[DW-1:LW];
   assign dy1_hi = dy1[DW-1:LW];

   // num = dx1*dy0 - dx0*dy1
   assign a_lo0_in = dx1 * dy0_lo;
   assign a_hi0_in = dx1 * dy0_hi;
   assign a_lo1_in = dx0 * dy1_lo;
   assign a_hi1_in = dx0 * dy1_hi;
   assign a_valid_in = advance ? !queue_empty : a_valid_ff;

   assign b_prod0_in = (PW'(a_hi0_ff) <<< LW) + PW'(a_lo0_ff);
   assign b_prod1_in = (PW'(a_hi1_ff) <<< LW) + PW'(a_lo1_ff);
   assign b_valid_in = advance ? a_valid_ff : b_valid_ff;

   assign num     = (PW+1)'(b_prod0_ff) - (PW+1)'(b_prod1_ff);
   assign num_neg = num[PW];
   assign num_pos = !num_neg && (num != '0);
   // crossing right of the point when num has the sign of dy0 - dy1
   assign toggle  = (b_flags_ff.up && num_neg) || (b_flags_ff.down && num_pos);
   assign parity_new = b_flags_ff.first ? 1'b0 : (parity_ff ^ toggle);

   always_comb begin
      parity_in    = parity_ff;
      rsp_valid_in = rsp_valid_ff;
      inside_in    = inside_ff;
      if (advance) begin
         rsp_valid_in = b_valid_ff && b_flags_ff.last;
         if (b_valid_ff) begin
            parity_in = parity_new;
            inside_in = parity_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_lo0_ff   <= a_lo0_in;
         a_lo1_ff   <= a_lo1_in;
         a_hi0_ff   <= a_hi0_in;
         a_hi1_ff   <= a_hi1_in;
         a_flags_ff <= edge_flags;
         b_prod0_ff <= b_prod0_in;
         b_prod1_ff <= b_prod1_in;
         b_flags_ff <= a_flags_ff;
      end
      inside_ff <= inside_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         parity_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         parity_ff    <= parity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign inside_res = inside_ff;

endmodule

// ===== rtl/core/point_in_polygon_crossing_core.sv =====
// Crossing-number point-in-polygon test. Ring vertices stream in one item per cycle while
// req_tready is high; the item with req_tuser set starts a ring and latches the query point,
// and the item with req_tlast set produces one result whose bit 0 is 1 when the point lies
// inside. Every item after the first forms an edge from the previous vertex; no closing edge is
// added. The front end forms the vertex-minus-point deltas and classifies the edge in the
// accept cycle, a four-entry queue decouples it from the back end, and the back end runs an
// exact cross-product pipeline (split partial products, full products, then subtract and sign)
// ahead of the parity bit. Sustained rate is one item per cycle while the result is not
// stalled; after its last vertex is accepted, a result passes the queue, the partial-product
// stage, then the full-product stage whose subtract and sign feed the result register.
module point_in_polygon_crossing_core #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // vertex_x, vertex_y, point_x, point_y
   input  logic [pipc_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   // first_vertex
   input  logic                                req_tuser,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // inside_res, then zero fill
   output logic [pipc_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata
);
   import pipc_pkg::*;

   localparam int EDGE_WIDTH = 4 * (COORD_WIDTH + 1);

   logic                  accept, q_pop, inside_res;
   logic [EDGE_WIDTH-1:0] push_data, head_data;
   edge_flags_type        push_flags, head_flags;
   queue_status_type      q_stat;

   assign req_tready = !q_stat.full;
   assign accept     = req_tvalid && req_tready;

   pipc_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .edge_data  (push_data),
      .edge_flags (push_flags)
   );

   pipc_queue #(.DATA_WIDTH(EDGE_WIDTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_data  (push_data),
      .push_flags (push_flags),
      .pop        (q_pop),
      .head_data  (head_data),
      .head_flags (head_flags),
      .status     (q_stat)
   );

   pipc_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (q_stat.empty),
      .edge_data   (head_data),
      .edge_flags  (head_flags),
      .pop         (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .inside_res  (inside_res)
   );

   assign rsp_tdata = RSP_DATA_WIDTH'(inside_res);

   // the back end must not pull an item while its result register is blocked
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !q_pop)
      else $error("queue popped while result stalled");

   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("pop from empty queue");

   assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> (!rsp_tvalid && q_stat.empty))
      else $error("core not idle after reset");

endmodule

// ===== bench/tb_point_in_polygon_crossing_core.sv =====
// testbench of the point-in-polygon crossing core: directed rings, random rings, idling and drain
`timescale 1ns / 100ps

module tb_point_in_polygon_crossing_core;

   import pipc_pkg::*;

   localparam int          CYCLE_LIMIT  = 400000;
   localparam int          DRAIN_CYCLES = 16;
   localparam logic [31:0] CMAX         = 32'h7fff_ffff;
   localparam logic [31:0] CMIN         = 32'h8000_0000;
   localparam logic [31:0] JUNK         = 32'hffff_ffff;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata  = '0;
   logic                      req_tuser  = 1'b0;
   logic                      req_tlast  = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;

   // predictor state: previous vertex, latched query point, crossing parity
   logic signed [31:0] prev_x = '0;
   logic signed [31:0] prev_y = '0;
   logic signed [31:0] query_x = '0;
   logic signed [31:0] query_y = '0;
   logic               parity = 1'b0;

   logic inside_expected[$];

   int sender_idle_pct   = 0;
   int receiver_idle_pct = 0;
   int cycle_count       = 0;
   int mismatch_count    = 0;
   int vertex_count      = 0;
   int ring_count        = 0;
   int result_count      = 0;
   int inside_count      = 0;

   point_in_polygon_crossing_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   // compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (inside_expected.size() == 0) begin
            $error("unexpected result: inside_res %0d", rsp_tdata[0]);
            mismatch_count++;
         end else begin
            automatic logic want = inside_expected.pop_front();
            result_count++;
            if (rsp_tdata[0] != want) begin
               $error("inside_res mismatch: expected %0d, actual %0d", want, rsp_tdata[0]);
               mismatch_count++;
            end
            if (rsp_tdata[RSP_DATA_WIDTH-1:1] != '0) begin
               $error("zero fill mismatch: expected 0, actual %0h",
                      rsp_tdata[RSP_DATA_WIDTH-1:1]);
               mismatch_count++;
            end
         end
      end
   end

   // edge test on the accepted vertex, exact cross-product sign
   task automatic predict_vertex(input logic [31:0] vx, vy, px, py, input logic first, last);
      logic signed [32:0] dx0, dy0, dx1, dy1;
      logic signed [67:0] num;
      logic               up, down;
      begin
         if (first) begin
            query_x = px;
            query_y = py;
            parity  = 1'b0;
            ring_count++;
         end else begin
            dx0  = prev_x - query_x;
            dy0  = prev_y - query_y;
            dx1  = $signed(vx) - query_x;
            dy1  = $signed(vy) - query_y;
            up   = (dy0 <= 0) && (dy1 > 0);
            down = (dy0 > 0) && (dy1 <= 0);
            num  = dx1 * dy0;
            num  = num - dx0 * dy1;
            if ((up && num < 0) || (down && num > 0)) parity = ~parity;
         end
         prev_x = vx;
         prev_y = vy;
         if (last) begin
            inside_expected.push_back(parity);
            if (parity) inside_count++;
         end
      end
   endtask

   task automatic send_vertex(input logic [31:0] vx, vy, px, py, input logic first, last);
      begin
         while ($urandom_range(99) < sender_idle_pct) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= {py, px, vy, vx};
         req_tuser  <= first;
         req_tlast  <= last;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         predict_vertex(vx, vy, px, py, first, last);
         vertex_count++;
      end
   endtask

   // hold the sender until every expected result is back, then let the pipeline empty
   task automatic wait_for_results;
      begin
         req_tvalid <= 1'b0;
         while (inside_expected.size() != 0) @(posedge clock);
         repeat (DRAIN_CYCLES) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] pick_coord(input int mode, input logic [31:0] centre);
      case (mode)
         0: pick_coord = centre + 32'($urandom_range(32)) - 32'd16;
         1: pick_coord = $urandom;
         2: begin
            case ($urandom_range(3))
               0:       pick_coord = CMIN;
               1:       pick_coord = CMAX;
               2:       pick_coord = '0;
               default: pick_coord = centre;
            endcase
         end
         default: pick_coord = centre + 32'($urandom_range(8192)) - 32'd4096;
      endcase
   endfunction

   task automatic test_directed_cases;
      begin
         // vertices before any ring start use the reset point and keep the parity going
         send_vertex(32'd640, -32'sd640, JUNK, JUNK, 1'b0, 1'b0);
         send_vertex(32'd640, 32'd640, JUNK, JUNK, 1'b0, 1'b1);
         // first and last on one item: no edge
         send_vertex(32'd5, 32'd5, 32'd1, 32'd1, 1'b1, 1'b1);
         // square with the point inside, horizontal edges included
         send_vertex(32'd0, 32'd0, 32'd320, 32'd320, 1'b1, 1'b0);
         send_vertex(32'd640, 32'd0, JUNK, JUNK, 1'b0, 1'b0);
         send_vertex(32'd640, 32'd640, JUNK, JUNK, 1'b0, 1'b0);
         send_vertex(32'd0, 32'd640, JUNK, JUNK, 1'b0, 1'b0);
         send_vertex(32'd0, 32'd0, JUNK, JUNK, 1'b0, 1'b1);
         // same square, point outside to the right
         send_vertex(32'd0, 32'd0, 32'd960, 32'd320, 1'b1, 1'b0);
         send_vertex(32'd640, 32'd0, JUNK, JUNK, 1'b0, 1'b0);
         send_vertex(32'd640, 32'd640, JUNK, JUNK, 1'b0, 1'b0);
         send_vertex(32'd0, 32'd640, JUNK, JUNK, 1'b0, 1'b0);
         send_vertex(32'd0, 32'd0, JUNK, JUNK, 1'b0, 1'b1);
         // point on the right edge: zero numerator is not counted
         send_vertex(32'd0, 32'd0, 32'd640, 32'd320, 1'b1, 1'b0);
         send_vertex(32'd640, 32'd0, JUNK, JUNK, 1'b0, 1'b0);
         send_vertex(32'd640, 32'd640, JUNK, JUNK, 1'b0, 1'b0);
         send_vertex(32'd0, 32'd640, JUNK, JUNK, 1'b0, 1'b0);
         send_vertex(32'd0, 32'd0, JUNK, JUNK, 1'b0, 1'b1);
         // full-range square around the origin
         send_vertex(CMIN, CMIN, 32'd0, 32'd0, 1'b1, 1'b0);
         send_vertex(CMAX, CMIN, JUNK, JUNK, 1'b0, 1'b0);
         send_vertex(CMAX, CMAX, JUNK, JUNK, 1'b0, 1'b0);
         send_vertex(CMIN, CMAX, JUNK, JUNK, 1'b0, 1'b0);
         send_vertex(CMIN, CMIN, JUNK, JUNK, 1'b0, 1'b1);
         // stray vertices after a ring has ended
         send_vertex(CMAX, 32'd0, JUNK, JUNK, 1'b0, 1'b0);
         send_vertex(32'd0, CMAX, JUNK, JUNK, 1'b0, 1'b1);
         wait_for_results();
      end
   endtask

   // mostly well-formed rings near the point, some with broken first/last marking
   task automatic test_random_rings(input int item_total);
      int          sent, len, ring_mode, mode, sel;
      logic        noise, first, last;
      logic [31:0] px, py, x0, y0, vx, vy, qx, qy;
      begin
         sent = 0;
         while (sent < item_total) begin
            len       = ($urandom_range(9) == 0) ? $urandom_range(16, 9) : $urandom_range(6, 1);
            noise     = ($urandom_range(9) == 0);
            ring_mode = ($urandom_range(3) == 0) ? $urandom_range(3) :
                        (($urandom_range(1) == 0) ? 0 : 3);
            sel       = $urandom_range(3);
            px        = (sel < 2) ? $urandom : pick_coord(2, 32'($urandom_range(255)));
            py        = (sel < 2) ? $urandom : pick_coord(2, 32'($urandom_range(255)));
            x0        = '0;
            y0        = '0;
            for (int i = 0; i < len; i++) begin
               mode = ($urandom_range(3) == 0) ? $urandom_range(3) : ring_mode;
               vx   = pick_coord(mode, px);
               vy   = pick_coord(mode, py);
               if (i == 0) begin
                  x0 = vx;
                  y0 = vy;
               end else if (i == len - 1 && len > 2 && $urandom_range(1) == 1) begin
                  vx = x0;
                  vy = y0;
               end
               first = (i == 0);
               last  = (i == len - 1);
               if (noise) begin
                  first = ($urandom_range(3) == 0);
                  last  = ($urandom_range(3) == 0);
               end
               qx = (i == 0) ? px : $urandom;
               qy = (i == 0) ? py : $urandom;
               send_vertex(vx, vy, qx, qy, first, last);
               sent++;
            end
         end
      end
   endtask

   task automatic test_drain_pause;
      begin
         send_vertex(32'd0, 32'd0, 32'd64, 32'd64, 1'b1, 1'b0);
         send_vertex(32'd128, -32'sd64, JUNK, JUNK, 1'b0, 1'b0);
         send_vertex(32'd128, 32'd128, JUNK, JUNK, 1'b0, 1'b1);
         wait_for_results();
         send_vertex(32'd128, 32'd128, 32'd64, 32'd64, 1'b1, 1'b0);
         send_vertex(32'd128, -32'sd64, JUNK, JUNK, 1'b0, 1'b1);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();

      sender_idle_pct   = 22;
      receiver_idle_pct = 82;
      test_random_rings(150);
      test_drain_pause();
      test_random_rings(150);
      wait_for_results();

      sender_idle_pct   = 82;
      receiver_idle_pct = 22;
      test_random_rings(310);
      wait_for_results();

      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      test_random_rings(330);
      wait_for_results();

      $display("covered %0d vertex items over %0d ring starts, %0d results checked (%0d inside)",
               vertex_count, ring_count, result_count, inside_count);
      $display("idling mixes 22/82, 82/22 and none, with a mid-stream drain and full-range coords");
      if (mismatch_count == 0 && inside_expected.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
